// File: sv/bchr_pkg.sv
// ----------------------------------------------------------------------------
// Button event detector package
// Shared types and constants for the button click, hold and release detector.
// ----------------------------------------------------------------------------
package bchr_pkg;

   localparam int MAX_BUTTONS = 4;
   localparam int BTN_IDX_W   = 2;
   localparam int TICK_W      = 32;
   localparam int FIELD_W     = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CLICK_EN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE_EN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_EN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_THRESH = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_PERIOD = 3'd5;

   typedef struct packed {
      logic                 capture;
      logic                 start_div;
      logic                 update;
      logic                 finish;
      logic [BTN_IDX_W-1:0] btn;
   } cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

// File: sv/bchr_if.sv
// ----------------------------------------------------------------------------
// Button event detector channels
// Valid/ready channels for pin level beats and event result beats.
// ----------------------------------------------------------------------------
interface bchr_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] pin_levels;

   modport source (output valid, output pin_levels, input ready);
   modport sink (input valid, input pin_levels, output ready);
endinterface

interface bchr_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] click_events;
   logic [3:0] hold_events;
   logic [3:0] release_events;
   logic [3:0] pressed_now;

   modport source (output valid, output click_events, output hold_events,
                   output release_events, output pressed_now, input ready);
   modport sink (input valid, input click_events, input hold_events,
                 input release_events, input pressed_now, output ready);
endinterface

// File: sv/bchr_mod.sv
// ----------------------------------------------------------------------------
// Button event detector remainder unit
// Iterative restoring remainder of a 32-bit count by a 16-bit period,
// two dividend bits per cycle.
// ----------------------------------------------------------------------------
module bchr_mod (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [bchr_pkg::TICK_W-1:0]    dividend,
   input  logic [bchr_pkg::FIELD_W-1:0]   divisor,
   output logic                           done,
   output logic                           rem_zero
);

   localparam int STEPS  = bchr_pkg::TICK_W / 2;
   localparam int STEP_W = $clog2(STEPS);

   logic [bchr_pkg::TICK_W-1:0]  shift_ff, shift_in;
   logic [bchr_pkg::FIELD_W-1:0] rem_ff, rem_in, rem_mid;
   logic [bchr_pkg::FIELD_W-1:0] div_ff;
   logic [STEP_W-1:0]            step_ff;
   logic                         busy_ff, done_ff;

   function automatic logic [bchr_pkg::FIELD_W-1:0] rstep(
      input logic [bchr_pkg::FIELD_W-1:0] r,
      input logic                         b,
      input logic [bchr_pkg::FIELD_W-1:0] d
   );
      logic [bchr_pkg::FIELD_W:0] t;
      t = {r, b};
      if (t >= {1'b0, d}) begin
         t = t - {1'b0, d};
      end
      return t[bchr_pkg::FIELD_W-1:0];
   endfunction

   always_comb begin
      rem_mid  = rstep(rem_ff, shift_ff[bchr_pkg::TICK_W-1], div_ff);
      rem_in   = rstep(rem_mid, shift_ff[bchr_pkg::TICK_W-2], div_ff);
      shift_in = {shift_ff[bchr_pkg::TICK_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            step_ff  <= '0;
            shift_ff <= dividend;
            rem_ff   <= '0;
            div_ff   <= divisor;
         end else if (busy_ff) begin
            shift_ff <= shift_in;
            rem_ff   <= rem_in;
            step_ff  <= step_ff + 1'b1;
            if (step_ff == STEP_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign rem_zero = (rem_ff == '0);

   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff) else $error("remainder unit did not start");
   a_last_done : assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && step_ff == STEP_W'(STEPS - 1)) |=> done_ff)
      else $error("remainder unit missed its done pulse");
   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done raised while busy");

endmodule

// File: sv/bchr_dp.sv
// ----------------------------------------------------------------------------
// Button event detector datapath
// Configuration registers, press counters, event accumulation and the
// result register.
// ----------------------------------------------------------------------------
module bchr_dp #(
   parameter int NUM_BUTTONS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [bchr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bchr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [3:0]                        pin_levels,
   input  logic                              rsp_take,
   input  bchr_pkg::cmd_type                 cmd,
   output bchr_pkg::status_type              status,
   output logic                              rsp_valid,
   output logic [3:0]                        click_events,
   output logic [3:0]                        hold_events,
   output logic [3:0]                        release_events,
   output logic [3:0]                        pressed_now
);

   localparam int         BTN_W    = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
   localparam logic [3:0] BTN_MASK = 4'((1 << NUM_BUTTONS) - 1);

   logic [3:0]                      active_low_ff, click_en_ff, rel_en_ff, hold_en_ff;
   logic [bchr_pkg::CSR_DATA_W-1:0] thr_ff, per_ff;
   logic [bchr_pkg::TICK_W-1:0]     cnt_ff [NUM_BUTTONS];
   logic [3:0]                      pressed_ff, clicks_ff, holds_ff, rels_ff;
   logic [3:0]                      rsp_click_ff, rsp_hold_ff, rsp_rel_ff, rsp_now_ff;
   logic                            rsp_valid_ff;

   logic [BTN_W-1:0]                idx;
   logic [bchr_pkg::TICK_W-1:0]     cnt, cnt_in;
   logic [bchr_pkg::FIELD_W-1:0]    thr, per;
   logic                            pressed, need_div, div_done, rem_zero;

   assign idx      = cmd.btn[BTN_W-1:0];
   assign cnt      = cnt_ff[idx];
   assign thr      = thr_ff[bchr_pkg::FIELD_W*cmd.btn +: bchr_pkg::FIELD_W];
   assign per      = per_ff[bchr_pkg::FIELD_W*cmd.btn +: bchr_pkg::FIELD_W];
   assign pressed  = pressed_ff[cmd.btn];
   assign need_div = pressed && hold_en_ff[cmd.btn] && (per != '0)
                     && (cnt > {{(bchr_pkg::TICK_W-bchr_pkg::FIELD_W){1'b0}}, thr});

   always_comb begin
      if (!pressed) begin
         cnt_in = '0;
      end else if (cnt != '1) begin
         cnt_in = cnt + 1'b1;
      end else begin
         cnt_in = cnt;
      end
   end

   bchr_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_div),
      .dividend (cnt),
      .divisor  (per),
      .done     (div_done),
      .rem_zero (rem_zero)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         active_low_ff <= '0;
         click_en_ff   <= '0;
         rel_en_ff     <= '0;
         hold_en_ff    <= '0;
         thr_ff        <= '0;
         per_ff        <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            bchr_pkg::REG_ACTIVE_LOW:  active_low_ff <= csr_wdata[3:0];
            bchr_pkg::REG_CLICK_EN:    click_en_ff   <= csr_wdata[3:0];
            bchr_pkg::REG_RELEASE_EN:  rel_en_ff     <= csr_wdata[3:0];
            bchr_pkg::REG_HOLD_EN:     hold_en_ff    <= csr_wdata[3:0];
            bchr_pkg::REG_HOLD_THRESH: thr_ff        <= csr_wdata;
            bchr_pkg::REG_HOLD_PERIOD: per_ff        <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else if (cmd.update) begin
         cnt_ff[idx] <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pressed_ff <= (pin_levels ^ active_low_ff) & BTN_MASK;
         clicks_ff  <= '0;
         holds_ff   <= '0;
         rels_ff    <= '0;
      end else if (cmd.update) begin
         clicks_ff[cmd.btn] <= pressed && (cnt == '0) && click_en_ff[cmd.btn];
         holds_ff[cmd.btn]  <= need_div && rem_zero;
         rels_ff[cmd.btn]   <= !pressed && (cnt != '0) && rel_en_ff[cmd.btn];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_click_ff <= clicks_ff;
         rsp_hold_ff  <= holds_ff;
         rsp_rel_ff   <= rels_ff;
         rsp_now_ff   <= pressed_ff;
      end
   end

   assign status.need_div = need_div;
   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || rsp_take;

   assign rsp_valid      = rsp_valid_ff;
   assign click_events   = rsp_click_ff;
   assign hold_events    = rsp_hold_ff;
   assign release_events = rsp_rel_ff;
   assign pressed_now    = rsp_now_ff;

endmodule

// File: sv/bchr_ctrl.sv
// ----------------------------------------------------------------------------
// Button event detector controller
// Walks the buttons of one tick, calling the remainder unit where a hold
// test needs it, and hands the result to the output register.
// ----------------------------------------------------------------------------
module bchr_ctrl #(
   parameter int NUM_BUTTONS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bchr_pkg::status_type  status,
   output bchr_pkg::cmd_type     cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EVAL   = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   localparam logic [bchr_pkg::BTN_IDX_W-1:0] LAST_BTN =
      bchr_pkg::BTN_IDX_W'(NUM_BUTTONS - 1);

   logic [2:0]                        state_ff, state_in;
   logic [bchr_pkg::BTN_IDX_W-1:0]    btn_ff, btn_in;

   always_comb begin
      state_in      = state_ff;
      btn_in        = btn_ff;
      cmd.capture   = 1'b0;
      cmd.start_div = 1'b0;
      cmd.update    = 1'b0;
      cmd.finish    = 1'b0;
      cmd.btn       = btn_ff;
      req_ready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               btn_in      = '0;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.need_div) begin
               cmd.start_div = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            if (btn_ff == LAST_BTN) begin
               state_in = ST_FINISH;
            end else begin
               btn_in   = btn_ff + 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         btn_ff   <= '0;
      end else begin
         state_ff <= state_in;
         btn_ff   <= btn_in;
      end
   end

   a_accept_eval : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EVAL && btn_ff == '0))
      else $error("accepted beat did not start the button walk");
   a_div_update : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && status.div_done) |=> state_ff == ST_UPDATE)
      else $error("remainder result not used");
   a_finish_free : assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> status.out_free)
      else $error("result written over an untaken beat");

endmodule

// File: sv/button_click_hold_release_events.sv
// ----------------------------------------------------------------------------
// Button click, hold and release event detector
// Each request beat carries one tick of raw pin levels; each tick yields
// exactly one response beat of click, hold, release and pressed masks.
// The block takes a request beat only while it is idle. It then visits the
// buttons one at a time, through an evaluate and an update state for each,
// waiting in a divide state when the hold test needs the remainder of the
// press count by the period, which is worked out two bits a cycle by a
// single shared unit.
// The response sits in an output register, so the next request beat is
// taken while a response waits; a stalled receiver only holds back the end
// of the following tick. Configuration is to be written through the csr_
// port only while the block is idle; the block does not enforce this. Reset
// clears the configuration, the press counters and the response valid flag.
// ----------------------------------------------------------------------------
module button_click_hold_release_events #(
   parameter int NUM_BUTTONS = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [bchr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bchr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   bchr_req_if.sink                         req_chan,
   bchr_rsp_if.source                       rsp_chan
);

   bchr_pkg::cmd_type    cmd;
   bchr_pkg::status_type status;

   bchr_ctrl #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bchr_dp #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .pin_levels     (req_chan.pin_levels),
      .rsp_take       (rsp_chan.ready),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_chan.valid),
      .click_events   (rsp_chan.click_events),
      .hold_events    (rsp_chan.hold_events),
      .release_events (rsp_chan.release_events),
      .pressed_now    (rsp_chan.pressed_now)
   );

endmodule
